// ===== rtl/core/sbpq_pkg.sv =====
// Shared types and constants for the stable bounded priority queue.
// Used by the controller, the datapath and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none
package sbpq_pkg;
	localparam int MAX_ENTRIES = 16;
	localparam int CNT_W = $clog2(MAX_ENTRIES + 1);
	localparam int CAP_W = 5;
	localparam int LIM_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
	localparam int DATA_W = 32;
	localparam int COUNT_OUT_W = 5;

	typedef logic [CNT_W-1:0] cnt_t;
	typedef logic [LIM_W-1:0] lim_t;
	typedef logic [CAP_W-1:0] cap_t;

	localparam cap_t CAP_RESET = cap_t'(16);

	typedef enum logic {
		KIND_ENQ = 1'b0,
		KIND_DEQ = 1'b1
	} kind_t;

	typedef enum logic [1:0] {
		ST_DONE = 2'd0,
		ST_REJ_FULL = 2'd1,
		ST_REJ_EMPTY = 2'd2
	} status_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic enq;
		logic deq;
		logic load_result;
		logic cap_write;
	} cmd_t;

	// Status from the datapath back to the controller.
	typedef struct packed {
		logic full;
		logic empty;
	} dp_status_t;
endpackage
`default_nettype wire

// ===== rtl/core/stable_bounded_priority_queue.sv =====
// Top level of the stable bounded priority queue.
// Joins sbpq_ctrl and sbpq_dp; depends on sbpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
// Bounded priority queue of (value, priority) pairs, highest priority at the
// head and equal priorities served in arrival order. For each request (kind 0
// enqueue, kind 1 dequeue) all sixteen slot cells compare their priority with
// the new one in parallel and shift in the same cycle, and one result with the
// head entry, count, flags and status is registered for the next cycle. A new
// request is taken in every cycle in which the result register is empty or its
// result is being taken, so the block sustains one request per cycle. There is
// no clearing pass after reset. The capacity register is written through the
// cfg channel, by the user only while idle; the block does not enforce this.
module stable_bounded_priority_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic        kind,
	input  wire logic signed [31:0] value,
	input  wire logic signed [31:0] priority_req,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic signed [31:0] head_value,
	output logic signed [31:0] head_priority,
	output logic [4:0]       entry_count,
	output logic             is_empty,
	output logic             is_full,
	output logic [1:0]       status,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [4:0]  cfg_data
);
	sbpq_pkg::cmd_t cmd;
	sbpq_pkg::dp_status_t dp_st;

	sbpq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.kind      (kind),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.dp_st     (dp_st),
		.cmd       (cmd),
		.status    (status)
	);

	sbpq_dp u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.cfg_data      (cfg_data),
		.value         (value),
		.priority_req  (priority_req),
		.dp_st         (dp_st),
		.head_value    (head_value),
		.head_priority (head_priority),
		.entry_count   (entry_count),
		.is_empty      (is_empty),
		.is_full       (is_full)
	);
endmodule
`default_nettype wire

// ===== rtl/core/sbpq_ctrl.sv =====
// Controller for the stable bounded priority queue: handshakes, operation
// decode and status code. Depends on sbpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbpq_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                in_valid,
	output logic                     in_ready,
	input  wire logic                kind,
	output logic                     out_valid,
	input  wire logic                out_ready,
	input  wire logic                cfg_valid,
	output logic                     cfg_ready,
	input  wire sbpq_pkg::dp_status_t dp_st,
	output sbpq_pkg::cmd_t           cmd,
	output logic [1:0]               status
);
	typedef enum logic {
		S_IDLE,
		S_HOLD
	} state_t;

	state_t state_q;
	sbpq_pkg::status_t status_q;
	sbpq_pkg::status_t status_next;
	logic accept;

	assign in_ready = (state_q == S_IDLE) || out_ready;
	assign accept = in_valid && in_ready;
	assign out_valid = (state_q == S_HOLD);
	assign cfg_ready = 1'b1;
	assign status = status_q;

	always_comb begin
		cmd.enq = 1'b0;
		cmd.deq = 1'b0;
		cmd.load_result = accept;
		cmd.cap_write = cfg_valid;
		status_next = sbpq_pkg::ST_DONE;
		if (kind == sbpq_pkg::KIND_ENQ) begin
			if (dp_st.full) begin
				status_next = sbpq_pkg::ST_REJ_FULL;
			end else begin
				cmd.enq = accept;
			end
		end else begin
			if (dp_st.empty) begin
				status_next = sbpq_pkg::ST_REJ_EMPTY;
			end else begin
				cmd.deq = accept;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			status_q <= sbpq_pkg::ST_DONE;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_HOLD;
					end
				end
				S_HOLD: begin
					if (out_ready && !accept) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if (accept) begin
				status_q <= status_next;
			end
		end
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && !out_ready) |-> !in_ready)
		else $error("request accepted while a result is stalled");
	a_single_op: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.enq && cmd.deq))
		else $error("enqueue and dequeue issued together");
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && kind == sbpq_pkg::KIND_ENQ && dp_st.full) |=>
		(status_q == sbpq_pkg::ST_REJ_FULL && out_valid))
		else $error("enqueue into a full queue not rejected");
endmodule
`default_nettype wire

// ===== rtl/core/sbpq_dp.sv =====
// Datapath for the stable bounded priority queue: a row of sorted slot cells,
// the count and capacity registers and the result registers. Depends on sbpq_pkg.
`timescale 1ns / 1ps
`default_nettype none
module sbpq_dp (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire sbpq_pkg::cmd_t                cmd,
	input  wire logic [sbpq_pkg::CAP_W-1:0]    cfg_data,
	input  wire logic signed [sbpq_pkg::DATA_W-1:0] value,
	input  wire logic signed [sbpq_pkg::DATA_W-1:0] priority_req,
	output sbpq_pkg::dp_status_t               dp_st,
	output logic signed [sbpq_pkg::DATA_W-1:0] head_value,
	output logic signed [sbpq_pkg::DATA_W-1:0] head_priority,
	output logic [sbpq_pkg::COUNT_OUT_W-1:0]   entry_count,
	output logic                               is_empty,
	output logic                               is_full
);
	logic signed [sbpq_pkg::DATA_W-1:0] val_q [sbpq_pkg::MAX_ENTRIES];
	logic signed [sbpq_pkg::DATA_W-1:0] pri_q [sbpq_pkg::MAX_ENTRIES];
	logic signed [sbpq_pkg::DATA_W-1:0] val_next [sbpq_pkg::MAX_ENTRIES];
	logic signed [sbpq_pkg::DATA_W-1:0] pri_next [sbpq_pkg::MAX_ENTRIES];
	logic [sbpq_pkg::MAX_ENTRIES-1:0] stay;
	sbpq_pkg::cnt_t count_q;
	sbpq_pkg::cnt_t count_next;
	sbpq_pkg::cap_t capacity_q;
	sbpq_pkg::lim_t cap_ext;
	sbpq_pkg::lim_t limit;
	logic signed [sbpq_pkg::DATA_W-1:0] head_value_q;
	logic signed [sbpq_pkg::DATA_W-1:0] head_priority_q;
	sbpq_pkg::cnt_t entry_count_q;
	logic is_empty_q;
	logic is_full_q;

	assign cap_ext = sbpq_pkg::lim_t'(capacity_q);
	assign limit = (cap_ext > sbpq_pkg::lim_t'(sbpq_pkg::MAX_ENTRIES)) ?
		sbpq_pkg::lim_t'(sbpq_pkg::MAX_ENTRIES) : cap_ext;
	assign dp_st.full = sbpq_pkg::lim_t'(count_q) >= limit;
	assign dp_st.empty = (count_q == '0);

	// Each occupied cell whose priority is at least the new one keeps its
	// entry; since the row is sorted these cells form a prefix.
	always_comb begin
		for (int i = 0; i < sbpq_pkg::MAX_ENTRIES; i++) begin
			stay[i] = (sbpq_pkg::cnt_t'(i) < count_q) && (pri_q[i] >= priority_req);
		end
	end

	always_comb begin
		for (int i = 0; i < sbpq_pkg::MAX_ENTRIES; i++) begin
			val_next[i] = val_q[i];
			pri_next[i] = pri_q[i];
			if (cmd.enq && !stay[i]) begin
				if (i == 0) begin
					val_next[i] = value;
					pri_next[i] = priority_req;
				end else if (stay[(i == 0) ? 0 : i - 1]) begin
					val_next[i] = value;
					pri_next[i] = priority_req;
				end else begin
					val_next[i] = val_q[(i == 0) ? 0 : i - 1];
					pri_next[i] = pri_q[(i == 0) ? 0 : i - 1];
				end
			end else if (cmd.deq && (i < sbpq_pkg::MAX_ENTRIES - 1)) begin
				val_next[i] = val_q[(i < sbpq_pkg::MAX_ENTRIES - 1) ? i + 1 : i];
				pri_next[i] = pri_q[(i < sbpq_pkg::MAX_ENTRIES - 1) ? i + 1 : i];
			end
		end
	end

	always_comb begin
		count_next = count_q;
		if (cmd.enq) begin
			count_next = count_q + 1'b1;
		end else if (cmd.deq) begin
			count_next = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		for (int i = 0; i < sbpq_pkg::MAX_ENTRIES; i++) begin
			val_q[i] <= val_next[i];
			pri_q[i] <= pri_next[i];
		end
		if (cmd.load_result) begin
			head_value_q <= (count_next == '0) ? '0 : val_next[0];
			head_priority_q <= (count_next == '0) ? '0 : pri_next[0];
			entry_count_q <= count_next;
			is_empty_q <= (count_next == '0);
			is_full_q <= sbpq_pkg::lim_t'(count_next) >= limit;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			capacity_q <= sbpq_pkg::CAP_RESET;
		end else begin
			count_q <= count_next;
			if (cmd.cap_write) begin
				capacity_q <= cfg_data;
			end
		end
	end

	assign head_value = head_value_q;
	assign head_priority = head_priority_q;
	assign entry_count = sbpq_pkg::COUNT_OUT_W'(entry_count_q);
	assign is_empty = is_empty_q;
	assign is_full = is_full_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= sbpq_pkg::cnt_t'(sbpq_pkg::MAX_ENTRIES))
		else $error("entry count beyond storage");
	a_enq_grows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |=> count_q == $past(count_q) + 1'b1)
		else $error("enqueue did not add an entry");
	a_enq_not_full: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.enq |-> !dp_st.full)
		else $error("enqueue into a full queue");
	a_deq_not_empty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.deq |-> (count_q != '0))
		else $error("dequeue from an empty queue");
endmodule
`default_nettype wire

// ===== dv/tb_top.sv =====
// Self-checking testbench for stable_bounded_priority_queue.
// Checks each result against a priority queue kept in the bench, over several capacity settings.
// Depends on sbpq_pkg and the RTL top level; reads no files.
`timescale 1ns / 1ps
module tb_top;
	import sbpq_pkg::*;

	typedef struct packed {
		logic signed [31:0] head_value;
		logic signed [31:0] head_priority;
		logic [4:0]         entry_count;
		logic               is_empty;
		logic               is_full;
		status_t            status;
	} queue_result_t;

	// One directed step: either a capacity write or a request, with an optional typed-in result.
	typedef struct packed {
		logic               is_cfg;
		kind_t              op;
		logic signed [31:0] val;
		logic signed [31:0] pri;
		cap_t               cap;
		logic               lit;
		queue_result_t      want;
	} dir_row_t;

	localparam logic signed [31:0] P_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [31:0] P_MIN = 32'sh8000_0000;
	localparam queue_result_t NO_WANT = '0;
	localparam int N_DIR = 19;
	localparam int N_PHASES = 8;

	localparam dir_row_t DIR_ROWS [N_DIR] = '{
		'{1'b0, KIND_DEQ, 32'sd0, 32'sd0, 5'd0, 1'b1,
			'{32'sd0, 32'sd0, 5'd0, 1'b1, 1'b0, ST_REJ_EMPTY}},
		'{1'b0, KIND_ENQ, P_MAX, P_MAX, 5'd0, 1'b1,
			'{P_MAX, P_MAX, 5'd1, 1'b0, 1'b0, ST_DONE}},
		'{1'b0, KIND_ENQ, P_MIN, P_MIN, 5'd0, 1'b0, NO_WANT},
		'{1'b0, KIND_ENQ, 32'sd1, 32'sd5, 5'd0, 1'b0, NO_WANT},
		'{1'b0, KIND_ENQ, 32'sd2, 32'sd5, 5'd0, 1'b0, NO_WANT},
		'{1'b0, KIND_ENQ, 32'sd3, 32'sd6, 5'd0, 1'b0, NO_WANT},
		'{1'b0, KIND_DEQ, 32'sd0, 32'sd0, 5'd0, 1'b0, NO_WANT},
		'{1'b0, KIND_DEQ, 32'sd0, 32'sd0, 5'd0, 1'b0, NO_WANT},
		'{1'b0, KIND_DEQ, 32'sd0, 32'sd0, 5'd0, 1'b0, NO_WANT},
		// Two entries remain; a capacity of one leaves the queue over its limit.
		'{1'b1, KIND_ENQ, 32'sd0, 32'sd0, 5'd1, 1'b0, NO_WANT},
		'{1'b0, KIND_ENQ, 32'sd7, 32'sd100, 5'd0, 1'b1,
			'{32'sd2, 32'sd5, 5'd2, 1'b0, 1'b1, ST_REJ_FULL}},
		'{1'b0, KIND_DEQ, 32'sd0, 32'sd0, 5'd0, 1'b0, NO_WANT},
		'{1'b0, KIND_DEQ, 32'sd0, 32'sd0, 5'd0, 1'b1,
			'{32'sd0, 32'sd0, 5'd0, 1'b1, 1'b0, ST_DONE}},
		'{1'b1, KIND_ENQ, 32'sd0, 32'sd0, 5'd0, 1'b0, NO_WANT},
		'{1'b0, KIND_ENQ, 32'sd9, 32'sd9, 5'd0, 1'b1,
			'{32'sd0, 32'sd0, 5'd0, 1'b1, 1'b1, ST_REJ_FULL}},
		'{1'b0, KIND_DEQ, 32'sd0, 32'sd0, 5'd0, 1'b1,
			'{32'sd0, 32'sd0, 5'd0, 1'b1, 1'b1, ST_REJ_EMPTY}},
		'{1'b1, KIND_ENQ, 32'sd0, 32'sd0, 5'd31, 1'b0, NO_WANT},
		'{1'b0, KIND_ENQ, -32'sd5, -32'sd5, 5'd0, 1'b0, NO_WANT},
		'{1'b0, KIND_ENQ, 32'sd6, 32'sd0, 5'd0, 1'b0, NO_WANT}
	};

	localparam int PHASE_CAP [N_PHASES] = '{16, 5, 31, 1, 17, 0, 12, 16};
	localparam int PHASE_ITEMS [N_PHASES] = '{250, 200, 250, 150, 250, 80, 250, 270};
	localparam int SEND_IDLE [4] = '{0, 69, 0, 7};
	localparam int RECV_STALL [4] = '{0, 0, 69, 7};

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	kind_t              kind;
	logic signed [31:0] value;
	logic signed [31:0] priority_req;
	logic               out_valid;
	logic               out_ready;
	logic signed [31:0] head_value;
	logic signed [31:0] head_priority;
	logic [4:0]         entry_count;
	logic               is_empty;
	logic               is_full;
	logic [1:0]         status;
	logic               cfg_valid;
	logic               cfg_ready;
	logic [4:0]         cfg_data;

	// Bench copy of the queue contents and the capacity register.
	logic signed [31:0] slot_val [MAX_ENTRIES];
	logic signed [31:0] slot_pri [MAX_ENTRIES];
	int                 held_count;
	int                 cap_setting;
	queue_result_t      pending_results [$];
	int                 fail_count;
	int                 send_idle_pct;
	int                 recv_stall_pct;

	stable_bounded_priority_queue DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.kind(kind),
		.value(value),
		.priority_req(priority_req),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.head_value(head_value),
		.head_priority(head_priority),
		.entry_count(entry_count),
		.is_empty(is_empty),
		.is_full(is_full),
		.status(status),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2_000_000;
		$display("stable_bounded_priority_queue: mismatch");
		$finish;
	end

	function automatic queue_result_t apply_queue_op(input kind_t op,
			input logic signed [31:0] val, input logic signed [31:0] pri);
		queue_result_t r;
		int lim;
		int pos;
		lim = (cap_setting > MAX_ENTRIES) ? MAX_ENTRIES : cap_setting;
		r.status = ST_DONE;
		if (op == KIND_ENQ) begin
			if (held_count >= lim) begin
				r.status = ST_REJ_FULL;
			end else begin
				// Entries of equal priority stay ahead, so ties leave in arrival order.
				pos = 0;
				while (pos < held_count && slot_pri[pos] >= pri)
					pos++;
				for (int i = held_count; i > pos; i--) begin
					slot_val[i] = slot_val[i-1];
					slot_pri[i] = slot_pri[i-1];
				end
				slot_val[pos] = val;
				slot_pri[pos] = pri;
				held_count++;
			end
		end else if (held_count == 0) begin
			r.status = ST_REJ_EMPTY;
		end else begin
			for (int i = 0; i + 1 < held_count; i++) begin
				slot_val[i] = slot_val[i+1];
				slot_pri[i] = slot_pri[i+1];
			end
			held_count--;
		end
		r.head_value = (held_count != 0) ? slot_val[0] : 32'sd0;
		r.head_priority = (held_count != 0) ? slot_pri[0] : 32'sd0;
		r.entry_count = 5'(held_count);
		r.is_empty = (held_count == 0);
		r.is_full = (held_count >= lim);
		return r;
	endfunction

	// Entered and left at a falling edge; valid stays high after acceptance until the caller
	// either presents the next request or lowers it.
	task automatic send_request(input kind_t op, input logic signed [31:0] val,
			input logic signed [31:0] pri, input logic use_lit, input queue_result_t lit);
		queue_result_t predicted;
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= op;
		value <= val;
		priority_req <= pri;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		predicted = apply_queue_op(op, val, pri);
		pending_results.push_back(use_lit ? lit : predicted);
		@(negedge clk);
	endtask

	task automatic write_capacity(input cap_t c);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (2) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= c;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		cap_setting = c;
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	always @(negedge clk) begin
		if (arst_n)
			out_ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	always @(posedge clk) begin
		queue_result_t want;
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$error("result with no request outstanding: head_value %0d", head_value);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (head_value !== want.head_value) begin
					$error("head_value: expected %0d, got %0d", want.head_value, head_value);
					fail_count++;
				end
				if (head_priority !== want.head_priority) begin
					$error("head_priority: expected %0d, got %0d",
						want.head_priority, head_priority);
					fail_count++;
				end
				if (entry_count !== want.entry_count) begin
					$error("entry_count: expected %0d, got %0d", want.entry_count, entry_count);
					fail_count++;
				end
				if (is_empty !== want.is_empty) begin
					$error("is_empty: expected %0d, got %0d", want.is_empty, is_empty);
					fail_count++;
				end
				if (is_full !== want.is_full) begin
					$error("is_full: expected %0d, got %0d", want.is_full, is_full);
					fail_count++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, got %0d", want.status, status);
					fail_count++;
				end
			end
		end
	end

	initial begin
		dir_row_t row;
		kind_t r_op;
		logic signed [31:0] r_pri;
		logic filling;
		int lim;
		fail_count = 0;
		held_count = 0;
		cap_setting = CAP_RESET;
		send_idle_pct = 0;
		recv_stall_pct = 0;
		arst_n = 1'b0;
		in_valid = 1'b0;
		kind = KIND_ENQ;
		value = '0;
		priority_req = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		repeat (5) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		for (int i = 0; i < N_DIR; i++) begin
			row = DIR_ROWS[i];
			if (row.is_cfg)
				write_capacity(row.cap);
			else
				send_request(row.op, row.val, row.pri, row.lit, row.want);
		end

		// Random part: the queue swings between filling and draining so that full, empty
		// and every depth in between are visited under each capacity.
		filling = 1'b1;
		for (int ph = 0; ph < N_PHASES; ph++) begin
			write_capacity(cap_t'(PHASE_CAP[ph]));
			send_idle_pct = SEND_IDLE[ph % 4];
			recv_stall_pct = RECV_STALL[ph % 4];
			for (int n = 0; n < PHASE_ITEMS[ph]; n++) begin
				if ($urandom_range(149) == 0) begin
					in_valid <= 1'b0;
					do @(negedge clk); while (pending_results.size() != 0);
				end
				lim = (cap_setting > MAX_ENTRIES) ? MAX_ENTRIES : cap_setting;
				if (held_count == 0)
					filling = 1'b1;
				else if (held_count >= lim)
					filling = 1'b0;
				r_op = ($urandom_range(99) < (filling ? 80 : 20)) ? KIND_ENQ : KIND_DEQ;
				// Mostly a narrow band of priorities so that ties are common.
				case ($urandom_range(9))
					0: begin
						r_pri = $urandom_range(1) ? P_MAX : P_MIN;
					end
					1, 2, 3: begin
						r_pri = $urandom;
					end
					default: begin
						r_pri = int'($urandom_range(6)) - 3;
					end
				endcase
				send_request(r_op, $urandom, r_pri, 1'b0, NO_WANT);
			end
		end

		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(negedge clk);
		repeat (10) @(posedge clk);
		if (fail_count == 0)
			$display("stable_bounded_priority_queue: match");
		else
			$display("stable_bounded_priority_queue: mismatch");
		$finish;
	end
endmodule

// ===== files.f =====
rtl/core/sbpq_pkg.sv
rtl/core/sbpq_ctrl.sv
rtl/core/sbpq_dp.sv
rtl/core/stable_bounded_priority_queue.sv
dv/tb_top.sv
